/* rtl/mwo_pkg.sv */
package mwo_pkg;

	// Fixed field widths
	localparam int FREQ_W    = 24;
	localparam int DUTY_W    = 16;
	localparam int SAMPLE_W  = 18;
	localparam int MODE_W    = 3;
	localparam int TUNE_W    = 24;
	localparam int START_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Phase increment = floor(frequency * tuning_scale / 256)
	localparam int INC_SHIFT = 8;
	localparam int PROD_W    = FREQ_W + TUNE_W + 1;
	localparam int INC_W     = FREQ_W + TUNE_W - INC_SHIFT;

	localparam logic [TUNE_W-1:0] TUNE_RESET = TUNE_W'(89478);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TUNING_SCALE = CFG_IDX_W'(2);

	typedef enum logic [MODE_W-1:0] {
		WAVE_SINE    = 3'd0,
		WAVE_SINE01  = 3'd1,
		WAVE_SAW01   = 3'd2,
		WAVE_SAW_BIP = 3'd3,
		WAVE_SQUARE  = 3'd4,
		WAVE_PULSE   = 3'd5
	} wave_mode_t;

	// Which source forms the final sample
	typedef enum logic [1:0] {
		SEL_SINE   = 2'd0,
		SEL_SINE01 = 2'd1,
		SEL_DIRECT = 2'd2
	} out_sel_t;

endpackage

/* rtl/mwo_sine_rom.sv */
module mwo_sine_rom #(
	parameter int ADDR_BITS     = 10,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [ADDR_BITS-1:0]          addr,
	output logic signed [OUT_FRAC_BITS+1:0] data
);

	localparam int DEPTH  = 1 << ADDR_BITS;
	localparam int DATA_W = OUT_FRAC_BITS + 2;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] Q30_ONE    = 64'd1 << 30;

	// Taylor series of sin in Q30, eight terms
	function automatic logic signed [63:0] sin_q30(input logic [63:0] a);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x2 = (a * a) >> 30;
		term = a;
		sum = $signed(a);
		for (int i = 1; i <= 7; i++) begin
			term = (term * x2) >> 30;
			case (i)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				5: term = term / 110;
				6: term = term / 156;
				default: term = term / 210;
			endcase
			if (i % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > $signed(Q30_ONE)) begin
			sum = $signed(Q30_ONE);
		end
		return sum;
	endfunction

	// Quarter-wave symmetric entry, rounded to OUT_FRAC_BITS
	function automatic logic signed [63:0] sine_entry(input int k);
		logic [63:0] half;
		logic [63:0] quarter;
		logic [63:0] pos;
		logic [63:0] ang;
		logic [63:0] s;
		logic [63:0] v;
		half = 64'(DEPTH) >> 1;
		quarter = 64'(DEPTH) >> 2;
		pos = 64'(k) & (half - 64'd1);
		if (pos > quarter) begin
			pos = half - pos;
		end
		ang = (pos * TWO_PI_Q30 + half) >> ADDR_BITS;
		s = 64'(sin_q30(ang));
		v = ((s << OUT_FRAC_BITS) + (64'd1 << 29)) >> 30;
		return (64'(k) >= half) ? -$signed(v) : $signed(v);
	endfunction

	logic signed [DATA_W-1:0] rom_w [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam logic signed [DATA_W-1:0] ENTRY = DATA_W'(sine_entry(k));
		assign rom_w[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data <= rom_w[addr];
		end
	end

endmodule

/* rtl/mwo_phase.sv */
module mwo_phase #(
	parameter int PHASE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [PHASE_BITS-1:0]             load_value,
	input  logic                              step,
	input  logic signed [mwo_pkg::INC_W-1:0]  inc,
	output logic [PHASE_BITS-1:0]             phase,
	output logic                              wrapped
);

	localparam int INC_W = mwo_pkg::INC_W;
	localparam int SUM_W = ((PHASE_BITS > INC_W) ? PHASE_BITS : INC_W) + 1;

	logic [PHASE_BITS-1:0] phase_q;
	logic                  wrapped_q;
	logic [SUM_W-1:0]      sum;
	logic                  wrap_next;

	// Bits above the phase catch an upward wrap; a negative step never flags
	assign sum = {{(SUM_W-PHASE_BITS){1'b0}}, phase_q} + SUM_W'(inc);
	assign wrap_next = !inc[INC_W-1] && (sum[SUM_W-1:PHASE_BITS] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			wrapped_q <= 1'b0;
		end else if (load) begin
			phase_q   <= load_value;
			wrapped_q <= 1'b0;
		end else if (step) begin
			phase_q   <= sum[PHASE_BITS-1:0];
			wrapped_q <= wrap_next;
		end
	end

	assign phase   = phase_q;
	assign wrapped = wrapped_q;

endmodule

/* rtl/mwo_shaper.sv */
module mwo_shaper #(
	parameter int PHASE_BITS    = 32,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic [PHASE_BITS-1:0]           phase,
	input  logic                            wrapped,
	input  logic [mwo_pkg::DUTY_W-1:0]      duty,
	input  mwo_pkg::wave_mode_t             mode,
	output mwo_pkg::out_sel_t               sel,
	output logic signed [OUT_FRAC_BITS+1:0] direct
);

	localparam int S_W    = OUT_FRAC_BITS + 2;
	localparam int DUTY_W = mwo_pkg::DUTY_W;
	localparam logic signed [S_W-1:0] ONE = S_W'(1) << OUT_FRAC_BITS;

	logic [PHASE_BITS+OUT_FRAC_BITS-1:0]   frac_wide;
	logic [PHASE_BITS+OUT_FRAC_BITS:0]     frac_wide_bip;
	logic [DUTY_W+PHASE_BITS-1:0]          duty_wide;
	logic [OUT_FRAC_BITS-1:0]              frac;
	logic [OUT_FRAC_BITS:0]                frac_bip;
	logic [PHASE_BITS-1:0]                 duty_phase;

	// Take the top bits of the phase as a fraction, padding with zeros
	assign frac_wide     = {phase, {OUT_FRAC_BITS{1'b0}}};
	assign frac_wide_bip = {phase, {(OUT_FRAC_BITS+1){1'b0}}};
	assign duty_wide     = {duty, {PHASE_BITS{1'b0}}};
	assign frac          = frac_wide[PHASE_BITS+OUT_FRAC_BITS-1 -: OUT_FRAC_BITS];
	assign frac_bip      = frac_wide_bip[PHASE_BITS+OUT_FRAC_BITS -: OUT_FRAC_BITS+1];
	assign duty_phase    = duty_wide[DUTY_W+PHASE_BITS-1 -: PHASE_BITS];

	always_comb begin
		sel    = mwo_pkg::SEL_DIRECT;
		direct = '0;
		unique case (mode)
			mwo_pkg::WAVE_SINE:    sel = mwo_pkg::SEL_SINE;
			mwo_pkg::WAVE_SINE01:  sel = mwo_pkg::SEL_SINE01;
			mwo_pkg::WAVE_SAW01:   direct = $signed({2'b00, frac});
			mwo_pkg::WAVE_SAW_BIP: direct = $signed({1'b0, frac_bip}) - ONE;
			mwo_pkg::WAVE_SQUARE:  direct = (phase < duty_phase) ? ONE : '0;
			mwo_pkg::WAVE_PULSE:   direct = wrapped ? ONE : '0;
			default:               direct = '0;
		endcase
	end

endmodule

/* rtl/multi_waveform_oscillator_core.sv */
// Channel   | Signals                          | Moves
// ----------+----------------------------------+------------------------------------
// item      | item_valid/item_ready            | request: frequency, duty
// sample    | sample_valid/sample_ready        | one sample per request
// cfg       | cfg_wr_en, cfg_index, cfg_data   | register write, no handshake
//
// One request per cycle sustained while sample_ready stays high; a request is
// registered in stage 1, then stage 2, and sample_valid follows stage 2. Stage 1
// holds the phase increment (the only multiplier), stage 2 holds the sine ROM
// read data and the other waveforms, set as the phase advances.
// A stall on the sample side backs up through both stages; a free slot is
// refilled in the same cycle it drains. Reset clears both stages, loads the
// phase with zero and restores the register defaults.
module multi_waveform_oscillator_core #(
	parameter int PHASE_BITS     = 32,
	parameter int SINE_ADDR_BITS = 10,
	parameter int OUT_FRAC_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic signed [mwo_pkg::FREQ_W-1:0]    frequency,
	input  logic [mwo_pkg::DUTY_W-1:0]           duty,

	output logic                                 sample_valid,
	input  logic                                 sample_ready,
	output logic signed [mwo_pkg::SAMPLE_W-1:0]  sample,

	input  logic                                 cfg_wr_en,
	input  logic [mwo_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mwo_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int S_W      = OUT_FRAC_BITS + 2;
	localparam int SAMPLE_W = mwo_pkg::SAMPLE_W;
	localparam int PROD_W   = mwo_pkg::PROD_W;
	localparam int INC_W    = mwo_pkg::INC_W;
	localparam int MODE_W   = mwo_pkg::MODE_W;
	localparam int TUNE_W   = mwo_pkg::TUNE_W;
	localparam int START_W  = mwo_pkg::START_W;
	localparam int DUTY_W   = mwo_pkg::DUTY_W;
	localparam int SA_W     = START_W + PHASE_BITS;
	localparam logic signed [S_W:0] ONE_EXT = (S_W+1)'(1) << OUT_FRAC_BITS;

	// Configuration registers
	logic [MODE_W-1:0] wave_mode_q;
	logic [TUNE_W-1:0] tuning_q;
	logic              start_load;
	logic [SA_W-1:0]   start_wide;
	logic [PHASE_BITS-1:0] start_aligned;

	// Pipeline
	logic                     valid_s1;
	logic signed [INC_W-1:0]  inc_s1;
	logic [DUTY_W-1:0]        duty_s1;
	logic                     valid_s2;
	mwo_pkg::out_sel_t        sel_s2;
	logic signed [S_W-1:0]    direct_s2;
	logic signed [S_W-1:0]    sine_s2;

	logic                     ready_s2;
	logic                     move_s12;
	logic                     accept;
	logic signed [PROD_W-1:0] prod;

	logic [PHASE_BITS-1:0]    phase;
	logic                     wrapped;
	mwo_pkg::out_sel_t        sel;
	logic signed [S_W-1:0]    direct;
	logic signed [S_W:0]      sine01_sum;
	logic signed [S_W-1:0]    shaped;

	// Accept a write at once; index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= '0;
			tuning_q    <= mwo_pkg::TUNE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mwo_pkg::CFG_WAVE_MODE:    wave_mode_q <= cfg_data[MODE_W-1:0];
				mwo_pkg::CFG_TUNING_SCALE: tuning_q    <= cfg_data[TUNE_W-1:0];
				default: ;
			endcase
		end
	end

	// Start phase is a 0.32 fraction; top PHASE_BITS of it padded with zeros
	assign start_load    = cfg_wr_en && (cfg_index == mwo_pkg::CFG_START_PHASE);
	assign start_wide    = {cfg_data[START_W-1:0], {PHASE_BITS{1'b0}}};
	assign start_aligned = start_wide[SA_W-1 -: PHASE_BITS];

	// Handshake: each stage refills in the cycle it drains
	assign ready_s2     = !valid_s2 || sample_ready;
	assign move_s12     = valid_s1 && ready_s2;
	assign item_ready   = !valid_s1 || ready_s2;
	assign accept       = item_valid && item_ready;
	assign sample_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: signed frequency times unsigned scale, floor divide by 256
	assign prod = frequency * $signed({1'b0, tuning_q});

	always_ff @(posedge clk) begin
		if (accept) begin
			inc_s1  <= prod[PROD_W-2:mwo_pkg::INC_SHIFT];
			duty_s1 <= duty;
		end
	end

	// Phase accumulator advances as the request leaves stage 1
	mwo_phase #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (start_load),
		.load_value (start_aligned),
		.step       (move_s12),
		.inc        (inc_s1),
		.phase      (phase),
		.wrapped    (wrapped)
	);

	mwo_shaper #(
		.PHASE_BITS    (PHASE_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_shaper (
		.phase   (phase),
		.wrapped (wrapped),
		.duty    (duty_s1),
		.mode    (mwo_pkg::wave_mode_t'(wave_mode_q)),
		.sel     (sel),
		.direct  (direct)
	);

	// Stage 2: ROM read data registered alongside the other waveforms
	mwo_sine_rom #(
		.ADDR_BITS     (SINE_ADDR_BITS),
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_sine_rom (
		.clk   (clk),
		.rd_en (move_s12),
		.addr  (phase[PHASE_BITS-1 -: SINE_ADDR_BITS]),
		.data  (sine_s2)
	);

	always_ff @(posedge clk) begin
		if (move_s12) begin
			sel_s2    <= sel;
			direct_s2 <= direct;
		end
	end

	// Unipolar sine: (ONE + r) / 2, one bit wider so 2*ONE does not overflow
	assign sine01_sum = {sine_s2[S_W-1], sine_s2} + ONE_EXT;

	always_comb begin
		unique case (sel_s2)
			mwo_pkg::SEL_SINE:   shaped = sine_s2;
			mwo_pkg::SEL_SINE01: shaped = sine01_sum[S_W:1];
			mwo_pkg::SEL_DIRECT: shaped = direct_s2;
			default:             shaped = direct_s2;
		endcase
	end

	// Fit to the port: sign-extend or keep the low bits
	assign sample = SAMPLE_W'(shaped);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	// Modes and index that the package leaves unnamed
	localparam logic [mwo_pkg::MODE_W-1:0]    WAVE_SPARE_LO = 3'd6;
	localparam logic [mwo_pkg::MODE_W-1:0]    WAVE_SPARE_HI = 3'd7;
	localparam logic [mwo_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

	localparam logic signed [mwo_pkg::FREQ_W-1:0] FREQ_MAX = 24'sh7FFFFF;
	localparam logic signed [mwo_pkg::FREQ_W-1:0] FREQ_MIN = 24'sh800000;
	localparam logic [mwo_pkg::DUTY_W-1:0]        DUTY_MAX = 16'hFFFF;

	localparam int               ONE_Q16        = 1 << 16;
	localparam int               LUT_DEPTH      = 1 << 10;
	localparam longint unsigned  TWO_PI_Q30     = 64'd6746518852;
	localparam longint           Q30_UNITY      = 64'sd1 << 30;
	localparam int               RANDOM_ITEMS   = 1150;
	localparam int               WATCHDOG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                item_valid = 1'b0;
	logic                                item_ready;
	logic signed [mwo_pkg::FREQ_W-1:0]   frequency = '0;
	logic [mwo_pkg::DUTY_W-1:0]          duty = '0;
	logic                                sample_valid;
	logic                                sample_ready = 1'b0;
	logic signed [mwo_pkg::SAMPLE_W-1:0] sample;
	logic                                cfg_wr_en = 1'b0;
	logic [mwo_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [mwo_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	// Oscillator image kept by the bench
	int                         sine_lut [LUT_DEPTH];
	logic [2:0]                 wave_sel;
	logic [31:0]                phase_now;
	logic                       pulse_pending;
	logic [mwo_pkg::TUNE_W-1:0] tune;

	// Samples predicted for accepted requests, oldest first
	logic [mwo_pkg::SAMPLE_W-1:0] predicted_samples [$];

	int  fail_count = 0;
	int  reported = 0;
	int  idle_cycles = 0;
	int  sink_stall_left = 0;
	bit  sender_gaps = 1'b1;
	bit  sink_stalls = 1'b1;

	multi_waveform_oscillator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.frequency    (frequency),
		.duty         (duty),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Gap length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// Produce the sample for the current phase, then advance the phase by
	// floor(frequency * tune / 256) and note an upward wrap for the pulse train.
	function automatic logic [mwo_pkg::SAMPLE_W-1:0] oscillator_next(
		input logic signed [mwo_pkg::FREQ_W-1:0] freq,
		input logic [mwo_pkg::DUTY_W-1:0] high_frac
	);
		longint           step_inc;
		longint unsigned  phase_sum;
		int               level;
		int               lut_val;
		lut_val = sine_lut[phase_now[31:22]];
		step_inc = (longint'(freq) * longint'(tune)) >>> 8;
		case (wave_sel)
			mwo_pkg::WAVE_SINE:    level = lut_val;
			mwo_pkg::WAVE_SINE01:  level = (ONE_Q16 + lut_val) >>> 1;
			mwo_pkg::WAVE_SAW01:   level = int'(phase_now[31:16]);
			mwo_pkg::WAVE_SAW_BIP: level = int'(phase_now[31:15]) - ONE_Q16;
			mwo_pkg::WAVE_SQUARE:
				level = (phase_now < {high_frac, 16'h0000}) ? ONE_Q16 : 0;
			mwo_pkg::WAVE_PULSE:   level = pulse_pending ? ONE_Q16 : 0;
			default:               level = 0;
		endcase
		phase_sum = {32'h0, phase_now} + step_inc;
		// only a positive step past the top of the cycle counts as a wrap
		pulse_pending = (step_inc > 0) && (phase_sum > 64'hFFFF_FFFF);
		phase_now = phase_sum[31:0];
		return level[mwo_pkg::SAMPLE_W-1:0];
	endfunction

	// Build the quarter-wave sine table with a Q30 Taylor series, rounded to Q16
	initial begin
		longint unsigned pos, ang, sq, term, v;
		longint          acc;
		int              k, n;
		for (k = 0; k < LUT_DEPTH; k++) begin
			pos = k & (LUT_DEPTH / 2 - 1);
			if (pos > LUT_DEPTH / 4)
				pos = LUT_DEPTH / 2 - pos;
			ang = (pos * TWO_PI_Q30 + LUT_DEPTH / 2) >> 10;
			sq = (ang * ang) >> 30;
			term = ang;
			acc = ang;
			for (n = 1; n <= 7; n++) begin
				term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > Q30_UNITY)
				acc = Q30_UNITY;
			v = ((longint'(acc) << 16) + (64'd1 << 29)) >> 30;
			sine_lut[k] = (k >= LUT_DEPTH / 2) ? -int'(v) : int'(v);
		end
	end

	// Sink side: accept samples, stall at random when stalls are enabled
	always @(posedge clk) begin
		if (sink_stall_left != 0) begin
			sink_stall_left <= sink_stall_left - 1;
			sample_ready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
			sink_stall_left <= pick_gap();
			sample_ready <= 1'b0;
		end else begin
			sample_ready <= 1'b1;
		end
	end

	// Compare each delivered sample with the oldest prediction
	always @(posedge clk) begin
		logic [mwo_pkg::SAMPLE_W-1:0] want;
		if (sample_valid && sample_ready) begin
			if (predicted_samples.size() == 0) begin
				fail_count++;
				if (reported < 10)
					$display("[%0t] sample %0d delivered with no request pending",
						$realtime, sample);
				reported++;
			end else begin
				want = predicted_samples.pop_front();
				if (sample !== want) begin
					fail_count++;
					if (reported < 10)
						$display("[%0t] sample mismatch: expected %0d, got %0d",
							$realtime, $signed(want), sample);
					reported++;
				end
			end
		end
	end

	// Stop a hung run: count cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (sample_valid && sample_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("multi_waveform_oscillator_core verification failed");
			$finish;
		end
	end

	// Send one request, after an optional gap; predict its sample on acceptance.
	// Returns in the time step of the accepting edge, leaving valid high.
	task automatic send_request(
		input logic signed [mwo_pkg::FREQ_W-1:0] freq,
		input logic [mwo_pkg::DUTY_W-1:0] high_frac
	);
		int gap;
		gap = (sender_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		frequency <= freq;
		duty <= high_frac;
		do
			@(posedge clk);
		while (!item_ready);
		predicted_samples.push_back(oscillator_next(freq, high_frac));
	endtask

	// Drop valid and hold until every predicted sample has come back
	task automatic drain_requests();
		item_valid <= 1'b0;
		while (predicted_samples.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one register while idle and mirror it in the bench's image
	task automatic write_reg(
		input logic [mwo_pkg::CFG_IDX_W-1:0] idx,
		input logic [mwo_pkg::CFG_DATA_W-1:0] value
	);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			mwo_pkg::CFG_WAVE_MODE:    wave_sel = value[mwo_pkg::MODE_W-1:0];
			mwo_pkg::CFG_START_PHASE: begin
				phase_now = value;
				pulse_pending = 1'b0;
			end
			mwo_pkg::CFG_TUNING_SCALE: tune = value[mwo_pkg::TUNE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Defaults after reset: sine, phase zero, default tuning
	task automatic test_defaults();
		send_request(FREQ_MAX, '0);
		send_request(FREQ_MIN, DUTY_MAX);
		send_request(24'sd1, 16'h8000);
		drain_requests();
	endtask

	// One pass through every mode value, the two spare ones included
	task automatic test_each_waveform();
		int m;
		for (m = 0; m < (1 << mwo_pkg::MODE_W); m++) begin
			write_reg(mwo_pkg::CFG_WAVE_MODE, mwo_pkg::CFG_DATA_W'(m));
			write_reg(mwo_pkg::CFG_START_PHASE, $urandom());
			if (m == int'(mwo_pkg::WAVE_SQUARE)) begin
				send_request(FREQ_MAX, '0);
				send_request(FREQ_MIN, DUTY_MAX);
			end
			send_request(mwo_pkg::FREQ_W'($urandom()), mwo_pkg::DUTY_W'($urandom()));
			drain_requests();
		end
	endtask

	// Upward wrap raises the pulse, a downward wrap does not,
	// and a start phase write clears a pending pulse
	task automatic test_wrap_flag();
		write_reg(mwo_pkg::CFG_WAVE_MODE, mwo_pkg::CFG_DATA_W'(mwo_pkg::WAVE_PULSE));
		write_reg(mwo_pkg::CFG_TUNING_SCALE,
			mwo_pkg::CFG_DATA_W'({mwo_pkg::TUNE_W{1'b1}}));
		write_reg(mwo_pkg::CFG_START_PHASE, 32'hFFFF_FF00);
		send_request(24'sd1, '0);
		send_request(24'sd0, '0);
		send_request(-24'sd1, '0);
		send_request(24'sd0, '0);
		send_request(FREQ_MAX, '0);
		drain_requests();
		write_reg(mwo_pkg::CFG_START_PHASE, 32'hFFFF_FFFF);
		send_request(24'sd0, '0);
		drain_requests();
	endtask

	// Zero tuning scale freezes the phase; a write to the spare index does nothing
	task automatic test_zero_tuning();
		write_reg(mwo_pkg::CFG_WAVE_MODE, mwo_pkg::CFG_DATA_W'(mwo_pkg::WAVE_SAW_BIP));
		write_reg(mwo_pkg::CFG_TUNING_SCALE, '0);
		write_reg(CFG_SPARE, $urandom());
		send_request(FREQ_MAX, DUTY_MAX);
		send_request(FREQ_MIN, '0);
		send_request(24'sh5A5A5A, 16'hA5A5);
		drain_requests();
	endtask

	// Bursts under random settings; some bursts run without sender gaps or sink stalls
	task automatic test_random_phases();
		int                                done, burst, i, r, phase_no;
		logic [mwo_pkg::MODE_W-1:0]        mode;
		logic [mwo_pkg::TUNE_W-1:0]        scale;
		logic signed [mwo_pkg::FREQ_W-1:0] freq;
		logic [mwo_pkg::DUTY_W-1:0]        high_frac;
		done = 0;
		phase_no = 0;
		while (done < RANDOM_ITEMS) begin
			drain_requests();
			r = $urandom_range(0, 99);
			mode = (r < 88) ?
				mwo_pkg::MODE_W'($urandom_range(mwo_pkg::WAVE_SINE, mwo_pkg::WAVE_PULSE)) :
				mwo_pkg::MODE_W'($urandom_range(WAVE_SPARE_LO, WAVE_SPARE_HI));
			write_reg(mwo_pkg::CFG_WAVE_MODE, {29'($urandom()), mode});
			if (phase_no == 0 || $urandom_range(0, 1) == 1) begin
				r = $urandom_range(0, 9);
				write_reg(mwo_pkg::CFG_START_PHASE, (r == 0) ? 32'h0 :
					(r == 1) ? 32'hFFFF_FFFF : 32'($urandom()));
			end
			if (phase_no == 0 || $urandom_range(0, 4) < 3) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					scale = '0;
				else if (r < 16)
					scale = mwo_pkg::TUNE_W'(1);
				else if (r < 24)
					scale = '1;
				else if (r < 50)
					scale = mwo_pkg::TUNE_RESET;
				else
					scale = mwo_pkg::TUNE_W'($urandom()) &
						mwo_pkg::TUNE_W'((1 << $urandom_range(1, 24)) - 1);
				write_reg(mwo_pkg::CFG_TUNING_SCALE, {8'($urandom()), scale});
			end
			sender_gaps = (phase_no % 5 != 2);
			sink_stalls = (phase_no % 5 != 2);
			burst = $urandom_range(10, 90);
			for (i = 0; i < burst && done < RANDOM_ITEMS; i++) begin
				// now and then let the pipeline run dry mid-burst
				if ($urandom_range(0, 39) == 0)
					drain_requests();
				r = $urandom_range(0, 99);
				if (r < 8) begin
					case ($urandom_range(0, 4))
						0: freq = FREQ_MAX;
						1: freq = FREQ_MIN;
						2: freq = -24'sd1;
						3: freq = 24'sd0;
						default: freq = 24'sd1;
					endcase
				end else if (r < 45) begin
					freq = mwo_pkg::FREQ_W'($urandom_range(0, 4000) - 2000);
				end else begin
					freq = mwo_pkg::FREQ_W'($urandom());
				end
				r = $urandom_range(0, 19);
				high_frac = (r == 0) ? '0 : (r == 1) ? DUTY_MAX :
					mwo_pkg::DUTY_W'($urandom());
				send_request(freq, high_frac);
				done++;
			end
			phase_no++;
		end
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		drain_requests();
	endtask

	initial begin
		// reset image of the oscillator
		wave_sel = mwo_pkg::WAVE_SINE;
		phase_now = '0;
		pulse_pending = 1'b0;
		tune = mwo_pkg::TUNE_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_each_waveform();
		test_wrap_flag();
		test_zero_tuning();
		test_random_phases();

		repeat (4) @(posedge clk);
		if (fail_count == 0 && predicted_samples.size() == 0)
			$display("multi_waveform_oscillator_core verification clean");
		else
			$display("multi_waveform_oscillator_core verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/mwo_pkg.sv
rtl/mwo_sine_rom.sv
rtl/mwo_phase.sv
rtl/mwo_shaper.sv
rtl/multi_waveform_oscillator_core.sv
verif/tb_top.sv
